// ===== hdl/bm_pkg.sv =====
// bm_pkg: opcodes, register codes, request types and sequencer states
// for byte_machine_core. No dependencies.
package bm_pkg;

    localparam logic [7:0] OP_LOAD  = 8'h01;
    localparam logic [7:0] OP_STORE = 8'h02;
    localparam logic [7:0] OP_SET   = 8'h04;
    localparam logic [7:0] OP_INC   = 8'h05;
    localparam logic [7:0] OP_DEC   = 8'h06;
    localparam logic [7:0] OP_JMP   = 8'h07;
    localparam logic [7:0] OP_PUSH  = 8'h10;
    localparam logic [7:0] OP_POP   = 8'h11;

    localparam logic [7:0] CODE_MAXB = 8'h07;
    localparam logic [7:0] CODE_IP   = 8'h08;
    localparam logic [7:0] CODE_SP   = 8'h09;
    localparam logic [7:0] CODE_BP   = 8'h0A;

    localparam logic [15:0] HI_MASK  = 16'hFF00;
    localparam logic [15:0] MINUS1   = 16'hFFFF;

    localparam logic [1:0] REQ_WR   = 2'd0;
    localparam logic [1:0] REQ_RD   = 2'd1;
    localparam logic [1:0] REQ_REG  = 2'd2;
    localparam logic [1:0] REQ_EXEC = 2'd3;

    typedef enum logic [10:0] {
        S_CLEAR = 11'b00000000001,
        S_IDLE  = 11'b00000000010,
        S_MEMRD = 11'b00000000100,
        S_FETCH = 11'b00000001000,
        S_EXEC  = 11'b00000010000,
        S_LDW   = 11'b00000100000,
        S_PUSH2 = 11'b00001000000,
        S_POPW  = 11'b00010000000,
        S_POPB  = 11'b00100000000,
        S_POPC  = 11'b01000000000,
        S_ADV   = 11'b10000000000
    } t_state;

endpackage

// ===== hdl/bm_add.sv =====
// bm_add: shared 16-bit wrapping adder used for the fetch address, register byte
// increment and decrement, stack pointer and ip advance steps. No dependencies.
module bm_add (
    input  logic [15:0] i_a,
    input  logic [15:0] i_b,
    output logic [15:0] o_sum
);
    assign o_sum = i_a + i_b;
endmodule

// ===== hdl/bm_mem.sv =====
// bm_mem: single-port byte memory, one access per cycle, registered read.
// No dependencies.
module bm_mem #(
    parameter int AW = 16
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_addr,
    input  logic [7:0]    i_wdata,
    output logic [7:0]    o_rdata
);
    logic [7:0] r_mem [2**AW];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

// ===== hdl/byte_machine_core.sv =====
// byte_machine_core: host request channel, memory, registers and sequencer.
// Depends on bm_pkg, bm_add, bm_mem.
//
// channel   | direction | signals
// request   | in        | start, i_req_type, i_address, i_write_data; busy is out
// result    | out       | o_done, o_read_data, o_instr_pointer, o_stack_pointer,
//           |           | o_frame_pointer, o_carry_out, o_halted
//
// Memory write and register read answer in the cycle after the request; memory read
// passes through S_MEMRD first. Execute fetches through the single memory port in
// S_FETCH, then runs S_EXEC, any extra data access and the ip advance in S_ADV through
// the shared adder; a stopped machine answers in the cycle after the request.
// After reset the memory is zeroed, one byte a cycle, with busy high. Results pulse
// o_done for one cycle; the receiver cannot stall.
module byte_machine_core #(
    parameter int MEM_ADDR_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_req_type,
    input  logic [15:0] i_address,
    input  logic [7:0]  i_write_data,
    output logic        o_done,
    output logic [7:0]  o_read_data,
    output logic [15:0] o_instr_pointer,
    output logic [15:0] o_stack_pointer,
    output logic [15:0] o_frame_pointer,
    output logic        o_carry_out,
    output logic        o_halted
);
    localparam int AW = MEM_ADDR_BITS;

    bm_pkg::t_state r_state;
    logic [AW-1:0]  r_clr;
    logic [2:0]     r_cnt;
    logic [7:0]     r_op, r_b1, r_b2, r_b3, r_hi;
    logic [2:0]     r_inc;
    logic [7:0]     r_regs [8];
    logic [15:0]    r_ip, r_sp, r_bp;
    logic           r_carry, r_stop, r_done;
    logic [7:0]     r_rdata;

    logic [15:0] w_a, w_b, w_sum, w_maddr, w_pop;
    logic        w_we;
    logic [7:0]  w_wdata, w_mrd, w_reg;
    logic [2:0]  w_ridx;
    logic        w_acc, w_bad;

    assign w_acc = start && (r_state == bm_pkg::S_IDLE);
    assign w_pop = {r_hi, w_mrd};

    bm_add u_add (.i_a(w_a), .i_b(w_b), .o_sum(w_sum));

    bm_mem #(.AW(AW)) u_mem (
        .i_clk(i_clk), .i_we(w_we), .i_addr(w_maddr[AW-1:0]),
        .i_wdata(w_wdata), .o_rdata(w_mrd)
    );

    assign w_ridx = (r_state == bm_pkg::S_IDLE) ? i_address[2:0] : r_b1[2:0];
    assign w_reg  = r_regs[w_ridx];

    always_comb begin
        w_bad = 1'b0;
        case (r_op)
            bm_pkg::OP_LOAD:  w_bad = r_b3 > bm_pkg::CODE_MAXB;
            bm_pkg::OP_SET:   w_bad = r_b2 > bm_pkg::CODE_MAXB;
            bm_pkg::OP_STORE,
            bm_pkg::OP_INC,
            bm_pkg::OP_DEC:   w_bad = r_b1 > bm_pkg::CODE_MAXB;
            bm_pkg::OP_JMP:   w_bad = 1'b0;
            bm_pkg::OP_PUSH,
            bm_pkg::OP_POP:   w_bad = r_b1 > bm_pkg::CODE_BP;
            default:          w_bad = 1'b1;
        endcase
    end

    always_comb begin
        w_a = r_sp;
        w_b = bm_pkg::MINUS1;
        case (r_state)
            bm_pkg::S_FETCH: begin
                w_a = r_ip;
                w_b = {13'd0, r_cnt};
            end
            bm_pkg::S_EXEC: begin
                if (r_op == bm_pkg::OP_INC) begin
                    w_a = {8'd0, w_reg};
                    w_b = 16'd1;
                end else if (r_op == bm_pkg::OP_DEC) begin
                    w_a = {8'd0, w_reg};
                end
            end
            bm_pkg::S_POPW, bm_pkg::S_POPB: w_b = 16'd1;
            bm_pkg::S_POPC: begin
                w_a = (r_b1 == bm_pkg::CODE_SP) ? w_pop : r_sp;
                w_b = 16'd2;
            end
            bm_pkg::S_ADV: begin
                w_a = r_ip;
                w_b = {13'd0, r_inc};
            end
            default: w_a = r_sp;
        endcase
    end

    always_comb begin
        w_maddr = w_sum;
        w_we    = 1'b0;
        w_wdata = w_reg;
        case (r_state)
            bm_pkg::S_CLEAR: begin
                w_maddr = 16'(r_clr);
                w_we    = 1'b1;
                w_wdata = 8'd0;
            end
            bm_pkg::S_IDLE: begin
                w_maddr = i_address;
                w_we    = w_acc && (i_req_type == bm_pkg::REQ_WR);
                w_wdata = i_write_data;
            end
            bm_pkg::S_EXEC: begin
                if (r_op == bm_pkg::OP_LOAD) begin
                    w_maddr = {r_b1, r_b2};
                end else if (r_op == bm_pkg::OP_STORE) begin
                    w_maddr = {r_b2, r_b3};
                    w_we    = !w_bad;
                end else if (r_op == bm_pkg::OP_POP) begin
                    w_maddr = r_sp;
                end else if (r_op == bm_pkg::OP_PUSH) begin
                    w_we = !w_bad;
                    case (r_b1)
                        bm_pkg::CODE_IP: w_wdata = r_ip[7:0];
                        bm_pkg::CODE_SP: w_wdata = w_sum[7:0];
                        bm_pkg::CODE_BP: w_wdata = r_bp[7:0];
                        default:         w_wdata = w_reg;
                    endcase
                end
            end
            bm_pkg::S_PUSH2: begin
                w_we    = 1'b1;
                w_wdata = r_hi;
            end
            default: w_maddr = w_sum;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bm_pkg::S_CLEAR;
            r_clr   <= '0;
            r_cnt   <= '0;
            r_ip    <= 16'd0;
            r_sp    <= bm_pkg::MINUS1;
            r_bp    <= bm_pkg::MINUS1;
            r_carry <= 1'b0;
            r_stop  <= 1'b0;
            r_done  <= 1'b0;
            r_inc   <= '0;
            for (int i = 0; i < 8; i++) begin
                r_regs[i] <= 8'd0;
            end
        end else begin
            r_done <= 1'b0;
            case (r_state)
                bm_pkg::S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (&r_clr) begin
                        r_state <= bm_pkg::S_IDLE;
                    end
                end
                bm_pkg::S_IDLE: begin
                    if (w_acc) begin
                        r_rdata <= 8'd0;
                        case (i_req_type)
                            bm_pkg::REQ_WR: r_done <= 1'b1;
                            bm_pkg::REQ_RD: r_state <= bm_pkg::S_MEMRD;
                            bm_pkg::REQ_REG: begin
                                r_done  <= 1'b1;
                                r_rdata <= (i_address <= 16'd7) ? w_reg : 8'd0;
                            end
                            default: begin
                                if (r_stop) begin
                                    r_done <= 1'b1;
                                end else begin
                                    r_cnt   <= '0;
                                    r_state <= bm_pkg::S_FETCH;
                                end
                            end
                        endcase
                    end
                end
                bm_pkg::S_MEMRD: begin
                    r_rdata <= w_mrd;
                    r_done  <= 1'b1;
                    r_state <= bm_pkg::S_IDLE;
                end
                bm_pkg::S_FETCH: begin
                    r_cnt <= r_cnt + 1'b1;
                    case (r_cnt)
                        3'd1:    r_op <= w_mrd;
                        3'd2:    r_b1 <= w_mrd;
                        3'd3:    r_b2 <= w_mrd;
                        3'd4:    r_b3 <= w_mrd;
                        default: r_op <= r_op;
                    endcase
                    if (r_cnt == 3'd4) begin
                        r_state <= bm_pkg::S_EXEC;
                    end
                end
                bm_pkg::S_EXEC: begin
                    r_state <= bm_pkg::S_ADV;
                    r_inc   <= 3'd2;
                    if (w_bad) begin
                        r_stop  <= 1'b1;
                        r_done  <= 1'b1;
                        r_state <= bm_pkg::S_IDLE;
                    end else begin
                        case (r_op)
                            bm_pkg::OP_LOAD: begin
                                r_inc   <= 3'd4;
                                r_state <= bm_pkg::S_LDW;
                            end
                            bm_pkg::OP_STORE: r_inc <= 3'd4;
                            bm_pkg::OP_SET: begin
                                r_regs[r_b2[2:0]] <= r_b1;
                                r_inc <= 3'd3;
                            end
                            bm_pkg::OP_INC: begin
                                r_regs[r_b1[2:0]] <= w_sum[7:0];
                                r_carry <= w_sum[7:0] == 8'h00;
                            end
                            bm_pkg::OP_DEC: begin
                                r_regs[r_b1[2:0]] <= w_sum[7:0];
                                r_carry <= w_sum[7:0] == 8'hFF;
                            end
                            bm_pkg::OP_JMP: begin
                                r_ip    <= {r_b1, r_b2};
                                r_done  <= 1'b1;
                                r_state <= bm_pkg::S_IDLE;
                            end
                            bm_pkg::OP_PUSH: begin
                                r_sp <= w_sum;
                                if (r_b1 > bm_pkg::CODE_MAXB) begin
                                    r_state <= bm_pkg::S_PUSH2;
                                end
                                case (r_b1)
                                    bm_pkg::CODE_IP: r_hi <= 8'((r_ip & bm_pkg::HI_MASK) >> 8);
                                    bm_pkg::CODE_SP: r_hi <= w_sum[15:8];
                                    default:         r_hi <= r_bp[15:8];
                                endcase
                            end
                            default: begin
                                r_state <= (r_b1 > bm_pkg::CODE_MAXB) ? bm_pkg::S_POPB
                                                                      : bm_pkg::S_POPW;
                            end
                        endcase
                    end
                end
                bm_pkg::S_LDW: begin
                    r_regs[r_b3[2:0]] <= w_mrd;
                    r_state <= bm_pkg::S_ADV;
                end
                bm_pkg::S_PUSH2: begin
                    r_sp    <= w_sum;
                    r_state <= bm_pkg::S_ADV;
                end
                bm_pkg::S_POPW: begin
                    r_regs[r_b1[2:0]] <= w_mrd;
                    r_sp    <= w_sum;
                    r_state <= bm_pkg::S_ADV;
                end
                bm_pkg::S_POPB: begin
                    r_hi    <= w_mrd;
                    r_state <= bm_pkg::S_POPC;
                end
                bm_pkg::S_POPC: begin
                    if (r_b1 == bm_pkg::CODE_IP) begin
                        r_ip <= w_pop;
                    end
                    if (r_b1 == bm_pkg::CODE_BP) begin
                        r_bp <= w_pop;
                    end
                    r_sp    <= w_sum;
                    r_state <= bm_pkg::S_ADV;
                end
                bm_pkg::S_ADV: begin
                    r_ip    <= w_sum;
                    r_done  <= 1'b1;
                    r_state <= bm_pkg::S_IDLE;
                end
                default: r_state <= bm_pkg::S_IDLE;
            endcase
        end
    end

    assign busy            = r_state != bm_pkg::S_IDLE;
    assign o_done          = r_done;
    assign o_read_data     = r_rdata;
    assign o_instr_pointer = r_ip;
    assign o_stack_pointer = r_sp;
    assign o_frame_pointer = r_bp;
    assign o_carry_out     = r_carry;
    assign o_halted        = r_stop;

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> r_state == bm_pkg::S_IDLE)
        else $error("result beat while sequencer not idle");
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && !w_acc) |=> !r_done)
        else $error("result beat longer than one cycle");
    a_stop_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stop |=> r_stop)
        else $error("stop flag cleared without reset");
    a_fetch_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bm_pkg::S_FETCH && r_cnt == 3'd4) |=> r_state == bm_pkg::S_EXEC)
        else $error("fetch did not hand over to execute");
endmodule

// ===== bench/testbench.sv =====
// testbench: self-checking bench for byte_machine_core; queued host requests,
// predicted results compared field by field. Depends on bm_pkg and the core.
`timescale 1ns / 100ps

module testbench;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] addr;
        logic [7:0]  wdata;
        logic        drain;
    } t_req;

    typedef struct packed {
        logic [7:0]  rdata;
        logic [15:0] ip;
        logic [15:0] sp;
        logic [15:0] bp;
        logic        carry;
        logic        halt;
    } t_res;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  i_req_type = '0;
    logic [15:0] i_address = '0;
    logic [7:0]  i_write_data = '0;
    logic        o_done;
    logic [7:0]  o_read_data;
    logic [15:0] o_instr_pointer, o_stack_pointer, o_frame_pointer;
    logic        o_carry_out, o_halted;

    byte_machine_core dut (.*);

    always #1 i_clk = ~i_clk;

    // predictor state
    logic [7:0]  mdl_mem [0:65535];
    logic [7:0]  mdl_regs [0:7];
    logic [15:0] mdl_ip, mdl_sp, mdl_bp;
    logic        mdl_carry, mdl_halt;

    t_req pending_reqs [$];
    t_res expected_results [$];
    int   mismatches = 0;
    bit   stim_done = 1'b0;

    function automatic logic [15:0] word_at(input logic [15:0] a);
        return {mdl_mem[a], mdl_mem[16'(a + 1)]};
    endfunction

    function automatic void run_instr();
        logic [7:0]  op, a1, a2, a3;
        logic [15:0] ip, v;
        ip = mdl_ip;
        op = mdl_mem[ip];
        a1 = mdl_mem[16'(ip + 1)];
        a2 = mdl_mem[16'(ip + 2)];
        a3 = mdl_mem[16'(ip + 3)];
        case (op)
            bm_pkg::OP_LOAD: begin
                if (a3 > bm_pkg::CODE_MAXB) begin mdl_halt = 1'b1; return; end
                mdl_regs[a3[2:0]] = mdl_mem[{a1, a2}];
                mdl_ip = ip + 16'd4;
            end
            bm_pkg::OP_STORE: begin
                if (a1 > bm_pkg::CODE_MAXB) begin mdl_halt = 1'b1; return; end
                mdl_mem[{a2, a3}] = mdl_regs[a1[2:0]];
                mdl_ip = ip + 16'd4;
            end
            bm_pkg::OP_SET: begin
                if (a2 > bm_pkg::CODE_MAXB) begin mdl_halt = 1'b1; return; end
                mdl_regs[a2[2:0]] = a1;
                mdl_ip = ip + 16'd3;
            end
            bm_pkg::OP_INC, bm_pkg::OP_DEC: begin
                if (a1 > bm_pkg::CODE_MAXB) begin mdl_halt = 1'b1; return; end
                if (op == bm_pkg::OP_INC) begin
                    mdl_regs[a1[2:0]] = mdl_regs[a1[2:0]] + 8'd1;
                    mdl_carry = (mdl_regs[a1[2:0]] == 8'h00);
                end else begin
                    mdl_regs[a1[2:0]] = mdl_regs[a1[2:0]] - 8'd1;
                    mdl_carry = (mdl_regs[a1[2:0]] == 8'hFF);
                end
                mdl_ip = ip + 16'd2;
            end
            bm_pkg::OP_JMP: mdl_ip = word_at(ip + 16'd1);
            bm_pkg::OP_PUSH: begin
                if (a1 > bm_pkg::CODE_BP) begin mdl_halt = 1'b1; return; end
                mdl_sp = mdl_sp - 16'd1;
                if (a1 <= bm_pkg::CODE_MAXB) begin
                    mdl_mem[mdl_sp] = mdl_regs[a1[2:0]];
                end else begin
                    v = (a1 == bm_pkg::CODE_IP) ? mdl_ip
                      : (a1 == bm_pkg::CODE_SP) ? mdl_sp : mdl_bp;
                    mdl_mem[mdl_sp] = v[7:0];
                    mdl_mem[16'(mdl_sp - 1)] = v[15:8];
                    mdl_sp = mdl_sp - 16'd1;
                end
                mdl_ip = ip + 16'd2;
            end
            bm_pkg::OP_POP: begin
                if (a1 > bm_pkg::CODE_BP) begin mdl_halt = 1'b1; return; end
                if (a1 <= bm_pkg::CODE_MAXB) begin
                    mdl_regs[a1[2:0]] = mdl_mem[mdl_sp];
                    mdl_sp = mdl_sp + 16'd1;
                    mdl_ip = ip + 16'd2;
                end else begin
                    v = word_at(mdl_sp);
                    if (a1 == bm_pkg::CODE_IP) mdl_ip = v;
                    else if (a1 == bm_pkg::CODE_SP) mdl_sp = v;
                    else mdl_bp = v;
                    mdl_sp = mdl_sp + 16'd2;
                    mdl_ip = mdl_ip + 16'd2;
                end
            end
            default: mdl_halt = 1'b1;
        endcase
    endfunction

    function automatic t_res predict_request(input t_req r);
        t_res e;
        e.rdata = '0;
        case (r.kind)
            bm_pkg::REQ_WR:  mdl_mem[r.addr] = r.wdata;
            bm_pkg::REQ_RD:  e.rdata = mdl_mem[r.addr];
            bm_pkg::REQ_REG: e.rdata = (r.addr <= 16'd7) ? mdl_regs[r.addr[2:0]] : 8'h00;
            default: if (!mdl_halt) run_instr();
        endcase
        e.ip = mdl_ip;
        e.sp = mdl_sp;
        e.bp = mdl_bp;
        e.carry = mdl_carry;
        e.halt = mdl_halt;
        return e;
    endfunction

    task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // driver
    int   gap = 0;
    t_req cur;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && !busy) begin
            expected_results.push_back(predict_request(cur));
            start <= 1'b0;
            gap <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 19);
        end else if (!start && gap > 0) begin
            gap <= gap - 1;
        end else if (!start && pending_reqs.size() > 0) begin
            if (!pending_reqs[0].drain || expected_results.size() == 0) begin
                cur = pending_reqs.pop_front();
                start <= 1'b1;
                i_req_type <= cur.kind;
                i_address <= cur.addr;
                i_write_data <= cur.wdata;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_res e;
        if (i_rst_n && o_done) begin
            if (expected_results.size() == 0) begin
                report("unexpected beat", '0, '0);
            end else begin
                e = expected_results.pop_front();
                if (o_read_data !== e.rdata)
                    report("read_data", 16'(o_read_data), 16'(e.rdata));
                if (o_instr_pointer !== e.ip) report("instr_pointer", o_instr_pointer, e.ip);
                if (o_stack_pointer !== e.sp) report("stack_pointer", o_stack_pointer, e.sp);
                if (o_frame_pointer !== e.bp) report("frame_pointer", o_frame_pointer, e.bp);
                if (o_carry_out !== e.carry)
                    report("carry_out", 16'(o_carry_out), 16'(e.carry));
                if (o_halted !== e.halt)
                    report("halted", 16'(o_halted), 16'(e.halt));
            end
        end
    end

    task automatic add_req(input logic [1:0] k, input logic [15:0] a, input logic [7:0] d,
                           input logic drain = 1'b0);
        t_req r;
        r.kind = k;
        r.addr = a;
        r.wdata = d;
        r.drain = drain;
        pending_reqs.push_back(r);
    endtask

    // host-side view of memory, to place programs in the predicted address space
    task automatic poke(input logic [15:0] a, input logic [7:0] d);
        add_req(bm_pkg::REQ_WR, a, d);
    endtask

    function automatic logic [7:0] pick_op();
        case ($urandom_range(0, 9))
            0: return bm_pkg::OP_LOAD;
            1: return bm_pkg::OP_STORE;
            2: return bm_pkg::OP_SET;
            3: return bm_pkg::OP_INC;
            4: return bm_pkg::OP_DEC;
            5: return bm_pkg::OP_JMP;
            6: return bm_pkg::OP_PUSH;
            7: return bm_pkg::OP_POP;
            8: return 8'($urandom);
            default: return bm_pkg::OP_SET;
        endcase
    endfunction

    function automatic logic [7:0] pick_reg(input logic [7:0] op);
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return 8'($urandom);
        if ((op == bm_pkg::OP_PUSH || op == bm_pkg::OP_POP) && r < 6)
            return bm_pkg::CODE_IP + 8'($urandom_range(0, 2));
        return 8'($urandom_range(0, 7));
    endfunction

    // place one instruction at pc, then request one execute at the current ip
    task automatic run_at(input logic [15:0] pc, input logic [7:0] op, input logic [7:0] b1,
                          input logic [7:0] b2, input logic [7:0] b3);
        poke(pc, op);
        poke(pc + 16'd1, b1);
        poke(pc + 16'd2, b2);
        poke(pc + 16'd3, b3);
        add_req(bm_pkg::REQ_EXEC, 16'($urandom), 8'($urandom));
    endtask

    initial begin
        int n;
        logic [7:0] op;
        logic [15:0] pc;
        for (int i = 0; i < 65536; i++) mdl_mem[i] = 8'h00;
        for (int i = 0; i < 8; i++) mdl_regs[i] = 8'h00;
        mdl_ip = '0;
        mdl_sp = bm_pkg::MINUS1;
        mdl_bp = bm_pkg::MINUS1;
        mdl_carry = 1'b0;
        mdl_halt = 1'b0;

        // directed: extremes, every opcode in a chain of instructions from ip 0, wrap cases
        add_req(bm_pkg::REQ_RD, 16'hFFFF, 8'h00);
        add_req(bm_pkg::REQ_WR, 16'hFFFF, 8'hFF);
        add_req(bm_pkg::REQ_RD, 16'hFFFF, 8'h00);
        add_req(bm_pkg::REQ_REG, 16'd7, 8'h00);
        add_req(bm_pkg::REQ_REG, 16'hFFFF, 8'h00);
        run_at(16'h0000, bm_pkg::OP_SET, 8'hFF, 8'd7, 8'h00);
        run_at(16'h0003, bm_pkg::OP_INC, 8'd7, 8'h00, 8'h00);
        run_at(16'h0005, bm_pkg::OP_DEC, 8'd7, 8'h00, 8'h00);
        run_at(16'h0007, bm_pkg::OP_STORE, 8'd7, 8'hFF, 8'hFE);
        run_at(16'h000B, bm_pkg::OP_LOAD, 8'hFF, 8'hFF, 8'd0);
        run_at(16'h000F, bm_pkg::OP_PUSH, bm_pkg::CODE_IP, 8'h00, 8'h00);
        run_at(16'h0011, bm_pkg::OP_POP, bm_pkg::CODE_IP, 8'h00, 8'h00);
        run_at(16'h0013, bm_pkg::OP_PUSH, bm_pkg::CODE_SP, 8'h00, 8'h00);
        run_at(16'h0015, bm_pkg::OP_POP, bm_pkg::CODE_SP, 8'h00, 8'h00);
        run_at(16'h0017, bm_pkg::OP_JMP, 8'hFF, 8'hFE, 8'h00);
        run_at(16'hFFFE, bm_pkg::OP_SET, 8'h55, 8'd8, 8'h00);
        add_req(bm_pkg::REQ_EXEC, 16'h0000, 8'h00);
        add_req(bm_pkg::REQ_WR, 16'h0000, 8'h00);
        add_req(bm_pkg::REQ_RD, 16'hFFFE, 8'h00, 1'b1);

        // random: instructions at random places mixed with plain requests
        n = 0;
        while (n < 390) begin
            if ($urandom_range(0, 29) == 0) begin
                // restart stopped machine is impossible; add a request of a random kind
                add_req(2'($urandom), 16'($urandom), 8'($urandom));
                n++;
            end else begin
                op = pick_op();
                pc = 16'($urandom);
                run_at(pc, op, pick_reg(op), 8'($urandom), pick_reg(op));
                n += 5;
            end
            if ($urandom_range(0, 60) == 0)
                add_req(bm_pkg::REQ_REG, 16'($urandom_range(0, 15)), 8'd0, 1'b1);
        end
        stim_done = 1'b1;
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (!(stim_done && pending_reqs.size() == 0 && !start
                 && expected_results.size() == 0))
            @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #2000000;
        $display("status: fail");
        $finish;
    end
endmodule
